// ===== hw/rtl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared constants, byte types and the result record of the frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int FRAME_STORED = 9;
    localparam int POS_W        = 4;
    localparam int XOR_LAST_POS = 8;

    typedef logic [7:0]       t_byte;
    typedef logic [POS_W-1:0] t_pos;

    localparam t_byte XOR_SEED     = 8'hA5;
    localparam t_byte LINE_FEED    = 8'h0A;
    localparam t_byte ESC_CHECKSUM = 8'h1A;
    localparam t_byte MASK_ALIAS   = 8'h01;
    localparam t_byte MASK_TOP     = 8'h80;

    typedef struct packed {
        logic        frame_good;
        logic        is_read;
        logic [15:0] item_id;
        logic [31:0] item_value;
        t_byte       command_byte;
        t_byte       error_total;
    } t_result;

endpackage

// ===== hw/rtl/efr_stream_if.sv =====
// ----------------------------------------------------------------------------
// Frame receiver channels
// Valid/ready channels for received bytes and for decoded frame results.
// ----------------------------------------------------------------------------
interface efr_rx_if import efr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_res_if import efr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        frame_good;
    logic        is_read;
    logic [15:0] item_id;
    logic [31:0] item_value;
    t_byte       command_byte;
    t_byte       error_total;

    modport source (output valid, output frame_good, output is_read, output item_id,
                    output item_value, output command_byte, output error_total,
                    input ready);
    modport sink (input valid, input frame_good, input is_read, input item_id,
                  input item_value, input command_byte, input error_total,
                  output ready);
endinterface

// ===== hw/rtl/escaped_frame_receiver_top.sv =====
// A frame's result is shown in the cycle after its terminator byte is accepted.
// Throughput: one byte per cycle; the nine byte cells shift on accepted non-terminators.
// Only a terminator byte waits, and only while a result is still held at the output.
// Reset clears byte position, error counter and output valid and seeds the checksum;
// the byte cells hold no reset value and are filled before they are read.
// ----------------------------------------------------------------------------
// Escaped frame receiver top level
// Groups received bytes into ten-byte frames and emits one decoded result each.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_top import efr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efr_rx_if.sink    i_rx,
    efr_res_if.source o_res
);

    t_pos    r_pos;
    t_pos    n_pos;
    t_byte   r_xor;
    t_byte   n_xor;
    t_byte   r_err;
    logic    r_out_valid;
    t_result r_res;
    t_result dec_result;
    t_byte   cell_q [FRAME_STORED];
    t_byte   frame  [FRAME_STORED];
    logic    last;
    logic    rx_fire;
    logic    shift;

    assign last       = (r_pos >= t_pos'(FRAME_STORED));
    assign i_rx.ready = !last || !r_out_valid || o_res.ready;
    assign rx_fire    = i_rx.valid && i_rx.ready;
    assign shift      = rx_fire && !last;

    for (genvar k = 0; k < FRAME_STORED; k++) begin : g_cell
        if (k == 0) begin : g_head
            efr_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(shift),
                .i_byte (i_rx.rx_byte),
                .o_byte (cell_q[k])
            );
        end else begin : g_body
            efr_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(shift),
                .i_byte (cell_q[k-1]),
                .o_byte (cell_q[k])
            );
        end
        assign frame[k] = cell_q[FRAME_STORED-1-k];
    end

    efr_decode u_decode (
        .i_frame    (frame),
        .i_last_byte(i_rx.rx_byte),
        .i_xor      (r_xor),
        .i_err_count(r_err),
        .o_result   (dec_result)
    );

    always_comb begin
        n_pos = r_pos;
        n_xor = r_xor;
        if (rx_fire) begin
            if (last) begin
                n_pos = '0;
                n_xor = XOR_SEED;
            end else begin
                n_pos = r_pos + t_pos'(1);
                if (r_pos < t_pos'(XOR_LAST_POS)) begin
                    n_xor = r_xor ^ i_rx.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_xor       <= XOR_SEED;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_xor <= n_xor;
            if (rx_fire && last) begin
                r_err       <= dec_result.error_total;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire && last) begin
            r_res <= dec_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_good   = r_res.frame_good;
    assign o_res.is_read      = r_res.is_read;
    assign o_res.item_id      = r_res.item_id;
    assign o_res.item_value   = r_res.item_value;
    assign o_res.command_byte = r_res.command_byte;
    assign o_res.error_total  = r_res.error_total;

endmodule

// ===== hw/rtl/efr_cell.sv =====
// ----------------------------------------------------------------------------
// Frame byte cell
// One stage of the byte shift line; it takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module efr_cell import efr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_byte,
    output t_byte o_byte
);

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== hw/rtl/efr_decode.sv =====
// ----------------------------------------------------------------------------
// Frame decoder
// Checks terminator and checksum of a full frame and restores escaped bytes.
// ----------------------------------------------------------------------------
module efr_decode import efr_pkg::*; (
    input  t_byte   i_frame [FRAME_STORED],
    input  t_byte   i_last_byte,
    input  t_byte   i_xor,
    input  t_byte   i_err_count,
    output t_result o_result
);

    t_byte chk;
    t_byte mask;
    t_byte dec [7];
    logic  good;

    always_comb begin
        chk = i_frame[8];
        if (chk == ESC_CHECKSUM) begin
            chk = LINE_FEED;
        end
        good = (i_last_byte == LINE_FEED) && (chk == i_xor);

        mask = i_frame[7];
        if (mask == MASK_ALIAS) begin
            mask = LINE_FEED;
        end
        for (int i = 0; i < 7; i++) begin
            dec[i] = ((mask & (MASK_TOP >> i)) != '0) ? LINE_FEED : i_frame[i];
        end

        o_result = '0;
        if (good) begin
            o_result.frame_good   = 1'b1;
            o_result.is_read      = dec[6][0];
            o_result.item_id      = {dec[0], dec[1]};
            o_result.item_value   = {dec[2], dec[3], dec[4], dec[5]};
            o_result.command_byte = dec[6];
            o_result.error_total  = i_err_count;
        end else begin
            o_result.error_total  = i_err_count + 8'd1;
        end
    end

endmodule

// ===== hw/rtl/efr_checker.sv =====
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Watches the top level's ports for result hold, content and causality.
// ----------------------------------------------------------------------------
module efr_checker import efr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        i_rx_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_frame_good,
    input logic        i_is_read,
    input logic [15:0] i_item_id,
    input logic [31:0] i_item_value,
    input t_byte       i_command_byte,
    input t_byte       i_error_total
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_frame_good)
            && $stable(i_item_id) && $stable(i_item_value)
            && $stable(i_command_byte) && $stable(i_error_total))
        else $error("Result item changed while stalled.");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_frame_good |-> !i_is_read && i_item_id == '0
            && i_item_value == '0 && i_command_byte == '0)
        else $error("Rejected frame carries a nonzero payload.");

    a_read_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_is_read == i_command_byte[0])
        else $error("Read flag differs from command bit 0.");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready))
        else $error("Result item appeared without an accepted byte.");

endmodule

bind escaped_frame_receiver_top efr_checker u_efr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_valid    (i_rx.valid),
    .i_rx_ready    (i_rx.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_frame_good  (o_res.frame_good),
    .i_is_read     (o_res.is_read),
    .i_item_id     (o_res.item_id),
    .i_item_value  (o_res.item_value),
    .i_command_byte(o_res.command_byte),
    .i_error_total (o_res.error_total)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Sends ten-byte frames, some good and some broken, plus stray bytes. It
// predicts each decoded frame result and compares every result, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import efr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int FRAME_LEN   = 10;

    typedef t_byte t_frame [FRAME_LEN];
    typedef enum {FRAME_GOOD, FRAME_BAD_END, FRAME_BAD_SUM} t_frame_kind;

    class frame_checker;
        t_pos    pos;
        t_byte   cells [FRAME_STORED];
        t_byte   sum;
        t_byte   errs;
        int      mismatches;
        t_result pending_results [$];

        function new();
            pos        = '0;
            sum        = XOR_SEED;
            errs       = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            mismatches++;
        endtask

        function void take_rx_byte(t_byte b);
            t_byte   chk;
            t_byte   mask;
            t_byte   dec [7];
            t_result r;
            logic    good;
            if (pos < FRAME_STORED) begin
                cells[pos] = b;
                if (pos < XOR_LAST_POS) begin
                    sum = sum ^ b;
                end
                pos = pos + t_pos'(1);
                return;
            end
            chk = (cells[8] == ESC_CHECKSUM) ? LINE_FEED : cells[8];
            good = (b == LINE_FEED) && (chk == sum);
            pos = '0;
            sum = XOR_SEED;
            r = '0;
            if (good) begin
                mask = (cells[7] == MASK_ALIAS) ? LINE_FEED : cells[7];
                for (int i = 0; i < 7; i++) begin
                    dec[i] = ((mask & (MASK_TOP >> i)) != 0) ? LINE_FEED : cells[i];
                end
                r.frame_good   = 1'b1;
                r.is_read      = dec[6][0];
                r.item_id      = {dec[0], dec[1]};
                r.item_value   = {dec[2], dec[3], dec[4], dec[5]};
                r.command_byte = dec[6];
            end else begin
                errs = errs + 8'd1;
            end
            r.error_total = errs;
            pending_results.push_back(r);
        endfunction

        task check_frame_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no frame pending", 32'(got.error_total), 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.frame_good !== want.frame_good)
                report_mismatch("frame_good", 32'(got.frame_good), 32'(want.frame_good));
            if (got.is_read !== want.is_read)
                report_mismatch("is_read", 32'(got.is_read), 32'(want.is_read));
            if (got.item_id !== want.item_id)
                report_mismatch("item_id", 32'(got.item_id), 32'(want.item_id));
            if (got.item_value !== want.item_value)
                report_mismatch("item_value", got.item_value, want.item_value);
            if (got.command_byte !== want.command_byte)
                report_mismatch("command_byte", 32'(got.command_byte),
                                32'(want.command_byte));
            if (got.error_total !== want.error_total)
                report_mismatch("error_total", 32'(got.error_total),
                                32'(want.error_total));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    efr_rx_if  rx_if ();
    efr_res_if res_if ();

    escaped_frame_receiver_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    frame_checker sb;
    int           burst_left;
    int           cycles;
    int           bytes_sent;
    logic [11:0]  stall_cycle;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("escaped_frame_receiver_top verification failed");
            $finish;
        end
    end

    // The receiver cycles through full speed, coin-flip stalls, a fixed
    // periodic stall and rare stalls.
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 12'd1;
        case (stall_cycle[9:8])
            2'd0: begin
                res_if.ready <= 1'b1;
            end
            2'd1: begin
                res_if.ready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                res_if.ready <= (stall_cycle[3:0] < 4'd11);
            end
            default: begin
                res_if.ready <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_frame_result({res_if.frame_good, res_if.is_read, res_if.item_id,
                                   res_if.item_value, res_if.command_byte,
                                   res_if.error_total});
        end
    end

    task automatic send_byte(input t_byte b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                rx_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        sb.take_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame f);
        for (int i = 0; i < FRAME_LEN; i++) begin
            send_byte(f[i]);
        end
    endtask

    function automatic t_byte frame_sum(input t_frame f);
        t_byte s;
        s = XOR_SEED;
        for (int i = 0; i < 8; i++) begin
            s = s ^ f[i];
        end
        return s;
    endfunction

    function automatic t_byte pick_content();
        case ($urandom_range(0, 7))
            0: return LINE_FEED;
            1: return ESC_CHECKSUM;
            2: return 8'h00;
            3: return 8'hFF;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    // Stray bytes shift the frame boundary, so the remainder of the current
    // frame is filled before a shaped frame starts.
    task automatic send_shaped_frame(input t_frame_kind kind);
        t_frame f;
        t_byte  bad;
        while (sb.pos != 0) begin
            send_byte(pick_content());
        end
        for (int i = 0; i < 7; i++) begin
            f[i] = pick_content();
        end
        case ($urandom_range(0, 4))
            0: f[7] = MASK_ALIAS;
            1: f[7] = 8'h00;
            default: f[7] = t_byte'($urandom_range(0, 255));
        endcase
        f[8] = frame_sum(f);
        if (f[8] == LINE_FEED) begin
            f[8] = ESC_CHECKSUM;
        end
        f[9] = LINE_FEED;
        if (kind == FRAME_BAD_END) begin
            bad = t_byte'($urandom_range(0, 255));
            f[9] = (bad == LINE_FEED) ? ESC_CHECKSUM : bad;
        end else if (kind == FRAME_BAD_SUM) begin
            f[8] = f[8] ^ t_byte'($urandom_range(1, 255));
        end
        send_frame(f);
    endtask

    initial begin
        t_frame f;
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        stall_cycle   = '0;
        cycles        = 0;
        burst_left    = 0;
        bytes_sent    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A mask of one restores bytes 4 and 6 as well as nothing else.
        f = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, MASK_ALIAS, 8'h00, LINE_FEED};
        f[8] = frame_sum(f);
        send_frame(f);
        // Good checksum but a wrong terminator.
        f = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
        f[8] = frame_sum(f);
        send_frame(f);
        // Full mask including the unused low bit, and an escaped checksum.
        f = '{LINE_FEED, 8'h55, 8'hAA, LINE_FEED, 8'h12, 8'h34, 8'h00, 8'hFF, 8'h00,
              LINE_FEED};
        f[6] = frame_sum(f) ^ LINE_FEED;
        f[8] = ESC_CHECKSUM;
        send_frame(f);

        while (bytes_sent < 640) begin
            case ($urandom_range(0, 9))
                0: send_shaped_frame(FRAME_BAD_END);
                1: send_shaped_frame(FRAME_BAD_SUM);
                2: begin
                    repeat ($urandom_range(1, 7)) send_byte(t_byte'($urandom_range(0, 255)));
                end
                default: send_shaped_frame(FRAME_GOOD);
            endcase
        end

        rx_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("escaped_frame_receiver_top verification clean");
        end else begin
            $display("escaped_frame_receiver_top verification failed");
        end
        $finish;
    end

endmodule
